>>> rtl/core/mlfq_pkg.sv
package mlfq_pkg;

   localparam int NUM_LEVELS_DEF  = 3;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int OP_W     = 2;
   localparam int TASK_W   = 8;
   localparam int LVL_W    = 2;
   localparam int STATUS_W = 2;
   localparam int SLICE_W  = 8;
   localparam int MASK_W   = 3;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_SERVE   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_SLICE_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLICE_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLICE_TWO  = 2'd2;

   localparam logic [SLICE_W-1:0] SLICE_ZERO_RST = 8'd2;
   localparam logic [SLICE_W-1:0] SLICE_ONE_RST  = 8'd4;
   localparam logic [SLICE_W-1:0] SLICE_TWO_RST  = 8'd8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                served;
      logic [LVL_W-1:0]    level;
      logic [SLICE_W-1:0]  slice;
      logic [MASK_W-1:0]   empty_mask;
   } stage_type;

endpackage

>>> rtl/core/mlfq_ram.sv
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/multilevel_feedback_queue_scheduler.sv
// Three-level feedback queue scheduler. Each priority level (0 is the highest)
// is a ring FIFO of task identifiers held in one shared task RAM. A request is
// an enqueue on a level, a dequeue from a level, or a serve of the oldest task
// of the highest-priority non-empty level; every request gives one response
// with a status, the served task and level, that level's time slice and a mask
// of the levels left empty. One request is taken per clock cycle. The level
// pointers, the task RAM read and the response fields are registered at the
// transfer edge, and the output register takes them when the stage register
// moves on. The input stalls only while both registers hold responses that
// the receiver has not taken. The user must write the slice registers through
// the CSR port only while no request is in flight; the block does not enforce
// it, and the task RAM needs no clearing after reset.
module multilevel_feedback_queue_scheduler #(
   parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF,
   parameter int QUEUE_DEPTH = mlfq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // op [1:0], task_id [9:2], level [11:10], zero [15:12]
   input  logic [mlfq_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // status [1:0], served_task [9:2], served_level [11:10],
   // slice_length [19:12], empty_mask [22:20], zero [23]
   output logic [mlfq_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mlfq_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mlfq_pkg::SLICE_W-1:0]          csr_data
);

   import mlfq_pkg::*;

   localparam int HEAD_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int RAM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(RAM_DEPTH);

   logic [HEAD_W-1:0]  head_ff [0:NUM_LEVELS-1];
   logic [HEAD_W-1:0]  head_in [0:NUM_LEVELS-1];
   logic [CNT_W-1:0]   fill_ff [0:NUM_LEVELS-1];
   logic [CNT_W-1:0]   fill_in [0:NUM_LEVELS-1];
   logic [SLICE_W-1:0] slice_zero_ff, slice_one_ff, slice_two_ff;

   logic               s1_valid_ff;
   stage_type          s1_ff, s1_in;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [OP_W-1:0]    req_op;
   logic [TASK_W-1:0]  req_task;
   logic [LVL_W-1:0]   req_level;
   logic               accept, s1_move;
   logic               do_push, do_pop;
   logic [LVL_W-1:0]   target, serve_level;
   logic               serve_found;
   logic [HEAD_W-1:0]  sel_head;
   logic [CNT_W-1:0]   sel_fill;
   logic [ADDR_W-1:0]  sel_base;
   logic [SUM_W-1:0]   slot_sum;
   logic [HEAD_W-1:0]  wr_slot;
   logic [SUM_W-1:0]   next_sum;
   logic [HEAD_W-1:0]  next_head;
   logic               level_ok;
   logic [TASK_W-1:0]  ram_rd_data;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;

   assign req_op    = req_tdata[1:0];
   assign req_task  = req_tdata[9:2];
   assign req_level = req_tdata[11:10];

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      serve_found = 1'b0;
      serve_level = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (fill_ff[i] != '0) begin
            serve_found = 1'b1;
            serve_level = LVL_W'(i);
         end
      end

      target = (req_op == OP_SERVE) ? serve_level : req_level;
      level_ok = (32'(req_level) < NUM_LEVELS);

      sel_head = '0;
      sel_fill = '0;
      sel_base = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (target == LVL_W'(i)) begin
            sel_head = head_ff[i];
            sel_fill = fill_ff[i];
            sel_base = ADDR_W'(i * QUEUE_DEPTH);
         end
      end

      do_push = 1'b0;
      do_pop  = 1'b0;
      s1_in.status = ST_OK;
      case (req_op)
         OP_ENQUEUE: begin
            if (!level_ok) begin
               s1_in.status = ST_BAD_LEVEL;
            end else if (sel_fill == CNT_W'(QUEUE_DEPTH)) begin
               s1_in.status = ST_FULL;
            end else begin
               do_push = 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (!level_ok) begin
               s1_in.status = ST_BAD_LEVEL;
            end else if (sel_fill == '0) begin
               s1_in.status = ST_NONE;
            end else begin
               do_pop = 1'b1;
            end
         end
         OP_SERVE: begin
            if (serve_found) begin
               do_pop = 1'b1;
            end else begin
               s1_in.status = ST_NONE;
            end
         end
         default: s1_in.status = ST_BAD_LEVEL;
      endcase

      slot_sum = SUM_W'(sel_head) + SUM_W'(sel_fill);
      if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
         slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
      end
      wr_slot = slot_sum[HEAD_W-1:0];

      next_sum = SUM_W'(sel_head) + SUM_W'(1);
      if (next_sum >= SUM_W'(QUEUE_DEPTH)) begin
         next_sum = '0;
      end
      next_head = next_sum[HEAD_W-1:0];

      wr_addr = sel_base + ADDR_W'(wr_slot);
      rd_addr = sel_base + ADDR_W'(sel_head);

      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i] = head_ff[i];
         fill_in[i] = fill_ff[i];
         if (accept && target == LVL_W'(i)) begin
            if (do_push) begin
               fill_in[i] = fill_ff[i] + CNT_W'(1);
            end else if (do_pop) begin
               fill_in[i] = fill_ff[i] - CNT_W'(1);
               head_in[i] = next_head;
            end
         end
      end

      s1_in.empty_mask = '1;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         s1_in.empty_mask[i] = (fill_in[i] == '0);
      end

      s1_in.served = do_pop;
      s1_in.level  = do_pop ? target : '0;
      s1_in.slice  = '0;
      if (do_pop) begin
         case (target)
            REG_SLICE_ZERO: s1_in.slice = slice_zero_ff;
            REG_SLICE_ONE:  s1_in.slice = slice_one_ff;
            REG_SLICE_TWO:  s1_in.slice = slice_two_ff;
            default:        s1_in.slice = '0;
         endcase
      end
   end

   mlfq_ram #(
      .WIDTH (TASK_W),
      .DEPTH (RAM_DEPTH)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (accept && do_push),
      .wr_addr (wr_addr),
      .wr_data (req_task),
      .rd_en   (accept && do_pop),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         slice_zero_ff <= SLICE_ZERO_RST;
         slice_one_ff  <= SLICE_ONE_RST;
         slice_two_ff  <= SLICE_TWO_RST;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            fill_ff[i] <= fill_in[i];
         end
         if (csr_valid) begin
            case (csr_index)
               REG_SLICE_ZERO: slice_zero_ff <= csr_data;
               REG_SLICE_ONE:  slice_one_ff  <= csr_data;
               REG_SLICE_TWO:  slice_two_ff  <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_data_ff <= {1'b0, s1_ff.empty_mask, s1_ff.slice, s1_ff.level,
                         (s1_ff.served ? ram_rd_data : TASK_W'(0)), s1_ff.status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/sv/sched_check_pkg.sv
`timescale 1ns / 1ps

package sched_check_pkg;

   import mlfq_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   task_id;
      logic [LVL_W-1:0]    level;
      logic [SLICE_W-1:0]  slice_len;
      logic [MASK_W-1:0]   empty_mask;
   } sched_response_type;

   class sched_scoreboard;

      localparam int PRINT_CAP = 40;

      logic [TASK_W-1:0]  ring [NUM_LEVELS_DEF][QUEUE_DEPTH_DEF];
      int unsigned        head [NUM_LEVELS_DEF];
      int unsigned        fill [NUM_LEVELS_DEF];
      logic [SLICE_W-1:0] slice_tab [NUM_LEVELS_DEF];
      sched_response_type due_responses [$];
      int unsigned        mismatches;
      int unsigned        responses_seen;

      function new();
         for (int i = 0; i < NUM_LEVELS_DEF; i++) begin
            head[i] = 0;
            fill[i] = 0;
         end
         slice_tab[0] = SLICE_ZERO_RST;
         slice_tab[1] = SLICE_ONE_RST;
         slice_tab[2] = SLICE_TWO_RST;
         mismatches = 0;
         responses_seen = 0;
      endfunction

      function void write_slice(logic [CSR_IDX_W-1:0] idx, logic [SLICE_W-1:0] val);
         if (idx == REG_SLICE_ZERO || idx == REG_SLICE_ONE || idx == REG_SLICE_TWO) begin
            slice_tab[idx] = val;
         end
      endfunction

      function int unsigned pending();
         return due_responses.size();
      endfunction

      // Work out the response to one accepted request and update the queues.
      function void apply_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                                  logic [LVL_W-1:0] lvl);
         sched_response_type r;
         bit              served;
         int unsigned     from;
         r = '0;
         served = 1'b0;
         from = 0;
         case (op)
            OP_ENQUEUE: begin
               if (lvl >= NUM_LEVELS_DEF) begin
                  r.status = ST_BAD_LEVEL;
               end else if (fill[lvl] >= QUEUE_DEPTH_DEF) begin
                  r.status = ST_FULL;
               end else begin
                  ring[lvl][(head[lvl] + fill[lvl]) % QUEUE_DEPTH_DEF] = tid;
                  fill[lvl]++;
                  r.status = ST_OK;
               end
            end
            OP_DEQUEUE: begin
               if (lvl >= NUM_LEVELS_DEF) begin
                  r.status = ST_BAD_LEVEL;
               end else if (fill[lvl] == 0) begin
                  r.status = ST_NONE;
               end else begin
                  r.status = ST_OK;
                  served = 1'b1;
                  from = lvl;
               end
            end
            OP_SERVE: begin
               r.status = ST_NONE;
               for (int i = 0; i < NUM_LEVELS_DEF; i++) begin
                  if (!served && fill[i] != 0) begin
                     served = 1'b1;
                     from = i;
                     r.status = ST_OK;
                  end
               end
            end
            default: begin
               r.status = ST_BAD_LEVEL;
            end
         endcase
         if (served) begin
            r.task_id = ring[from][head[from]];
            head[from] = (head[from] + 1) % QUEUE_DEPTH_DEF;
            fill[from]--;
            r.level = LVL_W'(from);
            r.slice_len = slice_tab[from];
         end
         for (int i = 0; i < MASK_W; i++) begin
            r.empty_mask[i] = (i >= NUM_LEVELS_DEF) || (fill[i] == 0);
         end
         due_responses.push_back(r);
      endfunction

      task report(string msg);
         if (mismatches < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
         end
         mismatches++;
      endtask

      task check_response(logic [RSP_DATA_W-1:0] d);
         sched_response_type want;
         string           diffs;
         if (due_responses.size() == 0) begin
            report($sformatf("response %h arrived with no request outstanding", d));
            return;
         end
         want = due_responses.pop_front();
         diffs = "";
         if (d[1:0] != want.status) begin
            diffs = {diffs, $sformatf(" status got %0d want %0d", d[1:0], want.status)};
         end
         if (d[9:2] != want.task_id) begin
            diffs = {diffs, $sformatf(" task got %0d want %0d", d[9:2], want.task_id)};
         end
         if (d[11:10] != want.level) begin
            diffs = {diffs, $sformatf(" level got %0d want %0d", d[11:10], want.level)};
         end
         if (d[19:12] != want.slice_len) begin
            diffs = {diffs, $sformatf(" slice got %0d want %0d", d[19:12], want.slice_len)};
         end
         if (d[22:20] != want.empty_mask) begin
            diffs = {diffs, $sformatf(" mask got %b want %b", d[22:20], want.empty_mask)};
         end
         if (diffs != "") begin
            report($sformatf("response %0d:%s", responses_seen, diffs));
         end
         responses_seen++;
      endtask

   endclass

endpackage

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   import mlfq_pkg::*;
   import sched_check_pkg::*;

   localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
   localparam logic [LVL_W-1:0]     LEVEL_INVALID = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED    = 2'd3;
   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_CYCLES = 64;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [SLICE_W-1:0]      csr_data = '0;

   bit req_gaps_on = 1'b0;
   bit rsp_gaps_on = 1'b0;
   bit hold_rsp = 1'b0;

   sched_scoreboard sb;

   multilevel_feedback_queue_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
   end

   // The receiver draws a random stall before each transfer when its gaps are on,
   // or holds off for a long stretch when asked to, so that the request side backs up.
   initial begin
      int unsigned gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = rsp_gaps_on ? $urandom_range(0, 4) : 0;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                               logic [LVL_W-1:0] lvl);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, lvl, tid, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.apply_request(op, tid, lvl);
      @(negedge clock);
   endtask

   task automatic send_random(int unsigned enq_pct);
      int unsigned      pick;
      logic [OP_W-1:0]  op;
      logic [TASK_W-1:0] tid;
      logic [LVL_W-1:0] lvl;
      pick = $urandom_range(0, 99);
      tid = TASK_W'($urandom);
      lvl = LVL_W'($urandom_range(0, NUM_LEVELS_DEF - 1));
      if (pick < 4) begin
         op = OP_UNUSED;
         lvl = LVL_W'($urandom);
      end else if (pick < 8) begin
         op = pick[0] ? OP_ENQUEUE : OP_DEQUEUE;
         lvl = LEVEL_INVALID;
      end else if (pick < 8 + enq_pct) begin
         op = OP_ENQUEUE;
      end else if ($urandom_range(0, 9) < 4) begin
         op = OP_DEQUEUE;
      end else begin
         op = OP_SERVE;
         lvl = LVL_W'($urandom);
      end
      send_request(op, tid, lvl);
   endtask

   task automatic run_random(int unsigned count, int unsigned enq_pct);
      repeat (count) send_random(enq_pct);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [SLICE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_slice(idx, val);
      @(negedge clock);
   endtask

   task automatic set_slices(logic [SLICE_W-1:0] s0, logic [SLICE_W-1:0] s1,
                             logic [SLICE_W-1:0] s2);
      write_reg(REG_SLICE_ZERO, s0);
      write_reg(REG_SLICE_ONE, s1);
      write_reg(REG_SLICE_TWO, s2);
      write_reg(REG_UNUSED, SLICE_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_request(OP_SERVE, 8'h3C, 2'd0);
      send_request(OP_DEQUEUE, 8'h00, 2'd1);
      send_request(OP_DEQUEUE, 8'hFF, LEVEL_INVALID);
      send_request(OP_ENQUEUE, 8'h5A, LEVEL_INVALID);
      send_request(OP_UNUSED, 8'hFF, LEVEL_INVALID);
      send_request(OP_ENQUEUE, 8'h00, 2'd2);
      send_request(OP_ENQUEUE, 8'hFF, 2'd1);
      send_request(OP_ENQUEUE, 8'hA5, 2'd0);
      send_request(OP_SERVE, 8'h00, 2'd3);
      send_request(OP_SERVE, 8'hFF, 2'd0);
      send_request(OP_SERVE, 8'h00, 2'd0);
      for (int k = 0; k <= QUEUE_DEPTH_DEF; k++) begin
         send_request(OP_ENQUEUE, (k == 0) ? 8'hFF : TASK_W'(k * 13), 2'd2);
      end
      send_request(OP_DEQUEUE, 8'h00, 2'd2);

      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      run_random(300, 55);

      wait_drained();
      set_slices(8'd1, 8'd255, 8'd1);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      run_random(300, 50);

      wait_drained();
      set_slices(8'd255, 8'd128, 8'd255);
      rsp_gaps_on = 1'b1;
      hold_rsp = 1'b1;
      run_random(40, 80);
      req_gaps_on = 1'b1;
      run_random(260, 70);

      // A slice of zero is stored as written.
      wait_drained();
      set_slices(8'd0, 8'd7, 8'd200);
      run_random(300, 35);

      wait_drained();
      set_slices(SLICE_W'($urandom_range(1, 255)), SLICE_W'($urandom_range(1, 255)),
                 SLICE_W'($urandom_range(1, 255)));
      rsp_gaps_on = 1'b0;
      run_random(300, 50);

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_ram.sv
rtl/core/multilevel_feedback_queue_scheduler.sv
tb/sv/sched_check_pkg.sv
tb/sv/tb.sv
